FILE: sv/multilevel_feedback_scheduler_top_macros.svh
// assertion macros shared by the scheduler modules
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MLFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MLFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mlfs_pkg.sv
// shared types and constants of the multilevel feedback scheduler
`default_nettype none

package mlfs_pkg;

  localparam int PID_W    = 12;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CFG_W-1:0] DEFAULT_PRIO_RESET = 5'd8;
  localparam logic REG_DFLT_PRIO = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_READY     = 2'd0,
    MODE_DISPATCH  = 2'd1,
    MODE_WAITING   = 2'd2,
    MODE_TERMINATE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/mlfs_ifs.sv
// request and response channel interfaces of the scheduler
`default_nettype none

interface mlfs_req_if;
  logic                     valid;
  logic                     ready;
  logic [mlfs_pkg::MODE_W-1:0] mode;
  logic [mlfs_pkg::PID_W-1:0]  pid;

  modport source (output valid, output mode, output pid, input ready);
  modport sink (input valid, input mode, input pid, output ready);
endinterface

interface mlfs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mlfs_pkg::PID_W-1:0]    dispatched_pid;
  logic [mlfs_pkg::STATUS_W-1:0] status;

  modport source (output valid, output dispatched_pid, output status, input ready);
  modport sink (input valid, input dispatched_pid, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/mlfs_ctrl.sv
// controller state machine: clearing pass, item accept and commit
`default_nettype none
`include "multilevel_feedback_scheduler_top_macros.svh"

module mlfs_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire mlfs_pkg::dp_status_t   stat,
  output mlfs_pkg::ctrl_cmd_t         cmd
);

  mlfs_pkg::state_t state;
  mlfs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlfs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mlfs_pkg::S_CLEAR: begin
        if (stat.clr_last) state_next = mlfs_pkg::S_IDLE;
      end
      mlfs_pkg::S_IDLE: begin
        if (in_valid) state_next = mlfs_pkg::S_EXEC;
      end
      mlfs_pkg::S_EXEC: begin
        if (stat.out_free) state_next = mlfs_pkg::S_IDLE;
      end
      default: begin
        state_next = mlfs_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.clr_we = 1'b0;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      mlfs_pkg::S_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      mlfs_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mlfs_pkg::S_EXEC: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `MLFS_ASSERT_NEXT(a_one_item_at_a_time, cmd.accept, !in_ready && !cmd.accept, "item accepted while one is in flight")
  `MLFS_ASSERT_NEXT(a_commit_frees_input, cmd.commit, in_ready, "input not reopened after commit")
  `MLFS_ASSERT_SAME(a_no_accept_while_clearing, cmd.clr_we, !in_ready && !cmd.commit, "item taken during clearing pass")

endmodule

`default_nettype wire

FILE: sv/mlfs_datapath.sv
// datapath: priority table, level queue memory, queue pointers and result register
`default_nettype none
`include "multilevel_feedback_scheduler_top_macros.svh"

module mlfs_datapath #(
  parameter int PID_COUNT   = 4096,
  parameter int LEVELS      = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mlfs_pkg::ctrl_cmd_t               cmd,
  output mlfs_pkg::dp_status_t                   stat,
  input  wire logic [mlfs_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [mlfs_pkg::PID_W-1:0]        in_pid,
  input  wire logic [mlfs_pkg::CFG_W-1:0]        default_prio,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mlfs_pkg::PID_W-1:0]             out_pid,
  output logic [mlfs_pkg::STATUS_W-1:0]          out_status
);

  localparam int AW = $clog2(PID_COUNT);
  localparam int LW = $clog2(LEVELS);
  localparam int PW = $clog2(LEVELS + 2);
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int QN = LEVELS * QUEUE_DEPTH;
  localparam int QA = $clog2(QN);
  localparam int XW = mlfs_pkg::PID_W + 4;

  localparam logic [PW-1:0] PRIO_UNSET = '1;
  localparam logic [PW-1:0] PRIO_TOP   = PW'(LEVELS);
  localparam logic [PW-1:0] PRIO_ONE   = PW'(1);
  localparam logic [PW-1:0] PRIO_TWO   = PW'(2);
  localparam logic [CW-1:0] CNT_FULL   = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   SUM_WRAP   = (CW+1)'(QUEUE_DEPTH);

  // latched request
  mlfs_pkg::mode_t           req_mode;
  logic [mlfs_pkg::PID_W-1:0] req_pid;
  logic                      req_hit;
  logic [AW-1:0]             req_addr;
  logic [LW-1:0]             disp_level;
  logic                      disp_hit;

  // stores
  logic [PW-1:0]                prio_mem [PID_COUNT];
  logic [PW-1:0]                prio_rd;
  logic [mlfs_pkg::PID_W-1:0]   queue_mem [QN];
  logic [mlfs_pkg::PID_W-1:0]   queue_rd;
  logic [SW-1:0]                head [LEVELS];
  logic [CW-1:0]                cnt [LEVELS];
  logic [AW-1:0]                clr_addr;

  // combinational
  logic [XW-1:0]  pid_wide;
  logic [AW-1:0]  in_addr;
  logic           in_hit;
  logic [LEVELS-1:0] nonempty;
  logic [LW-1:0]  first_level;
  logic           any_nonempty;
  logic [PW-1:0]  dflt;
  logic [PW-1:0]  prio_new;
  logic [LW-1:0]  enq_level;
  logic [LW-1:0]  sel_level;
  logic [SW-1:0]  sel_head;
  logic [CW-1:0]  sel_cnt;
  logic [CW:0]    tail_sum;
  logic [SW-1:0]  tail_slot;
  logic [CW:0]    head_sum;
  logic [SW-1:0]  head_next;
  logic [QA-1:0]  q_base;
  logic           full;
  logic           do_enq;
  logic           do_pop;
  logic           prio_we;
  logic [mlfs_pkg::PID_W-1:0] res_pid;
  mlfs_pkg::status_t          res_status;

  assign pid_wide = XW'(in_pid);
  assign in_addr  = pid_wide[AW-1:0];
  assign in_hit   = 32'(in_pid) < 32'(PID_COUNT);

  always_comb begin
    first_level  = '0;
    any_nonempty = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = cnt[i] != '0;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) first_level = LW'(i);
    end
    any_nonempty = |nonempty;
  end

  // default priority clamped into 1..LEVELS
  always_comb begin
    if (default_prio == '0) begin
      dflt = PRIO_ONE;
    end else if (32'(default_prio) > 32'(LEVELS)) begin
      dflt = PRIO_TOP;
    end else begin
      dflt = PW'(default_prio);
    end
  end

  always_comb begin
    prio_new = prio_rd;
    case (req_mode)
      mlfs_pkg::MODE_READY: begin
        if (prio_rd == PRIO_UNSET) prio_new = dflt;
        else if (prio_rd < PRIO_TOP) prio_new = prio_rd + PRIO_ONE;
      end
      mlfs_pkg::MODE_WAITING: begin
        if (prio_rd == PRIO_UNSET) prio_new = PRIO_UNSET;
        else if (prio_rd > PRIO_ONE) prio_new = prio_rd - PRIO_TWO;
        else if (prio_rd == PRIO_ONE) prio_new = '0;
        else prio_new = PRIO_UNSET;
      end
      mlfs_pkg::MODE_TERMINATE: begin
        prio_new = '0;
      end
      default: begin
        prio_new = prio_rd;
      end
    endcase
  end

  assign enq_level = LW'(prio_new - PRIO_ONE);
  assign sel_level = cmd.accept ? first_level :
                     (req_mode == mlfs_pkg::MODE_DISPATCH) ? disp_level : enq_level;
  assign sel_head  = head[sel_level];
  assign sel_cnt   = cnt[sel_level];

  assign tail_sum  = (CW+1)'(sel_head) + (CW+1)'(sel_cnt);
  assign tail_slot = SW'((tail_sum >= SUM_WRAP) ? tail_sum - SUM_WRAP : tail_sum);
  assign head_sum  = (CW+1)'(sel_head) + (CW+1)'(1);
  assign head_next = SW'((head_sum >= SUM_WRAP) ? head_sum - SUM_WRAP : head_sum);
  assign q_base    = QA'(32'(sel_level) * QUEUE_DEPTH);

  assign full    = sel_cnt == CNT_FULL;
  assign prio_we = cmd.commit && req_hit && (req_mode != mlfs_pkg::MODE_DISPATCH);
  assign do_enq  = prio_we && (req_mode == mlfs_pkg::MODE_READY) && !full;
  assign do_pop  = cmd.commit && (req_mode == mlfs_pkg::MODE_DISPATCH) && disp_hit;

  always_comb begin
    res_pid    = '0;
    res_status = mlfs_pkg::STAT_DONE;
    case (req_mode)
      mlfs_pkg::MODE_DISPATCH: begin
        if (disp_hit) begin
          res_pid    = queue_rd;
          res_status = mlfs_pkg::STAT_DISPATCHED;
        end else begin
          res_status = mlfs_pkg::STAT_EMPTY;
        end
      end
      mlfs_pkg::MODE_READY: begin
        if (req_hit && full) res_status = mlfs_pkg::STAT_FULL;
      end
      default: begin
        res_status = mlfs_pkg::STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode   <= mlfs_pkg::mode_t'(in_mode);
      req_pid    <= in_pid;
      req_hit    <= in_hit;
      req_addr   <= in_addr;
      disp_level <= first_level;
      disp_hit   <= any_nonempty;
    end
  end

  // priority table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      prio_mem[clr_addr] <= PRIO_UNSET;
    end else if (prio_we) begin
      prio_mem[req_addr] <= prio_new;
    end
    if (cmd.accept) begin
      prio_rd <= prio_mem[in_addr];
    end
  end

  // level queue memory
  always_ff @(posedge clk) begin
    if (do_enq) begin
      queue_mem[q_base + QA'(tail_slot)] <= req_pid;
    end
    if (cmd.accept) begin
      queue_rd <= queue_mem[q_base + QA'(sel_head)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else if (do_pop) begin
      head[sel_level] <= head_next;
      cnt[sel_level]  <= sel_cnt - CW'(1);
    end else if (do_enq) begin
      cnt[sel_level] <= sel_cnt + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pid    <= res_pid;
      out_status <= res_status;
    end
  end

  assign stat = '{clr_last: clr_addr == AW'(PID_COUNT - 1),
                  out_free: !out_valid || out_ready};

  `MLFS_ASSERT_SAME(a_commit_into_free_reg, cmd.commit, !out_valid || out_ready,
                    "result register overwritten")
  `MLFS_ASSERT_SAME(a_pop_from_nonempty, do_pop, sel_cnt != '0,
                    "dispatch from an empty level")
  `MLFS_ASSERT_SAME(a_count_in_bounds,
                    cmd.commit && req_hit && req_mode == mlfs_pkg::MODE_READY,
                    sel_cnt <= CNT_FULL, "level count above queue depth")

endmodule

`default_nettype wire

FILE: sv/multilevel_feedback_scheduler_top.sv
// top level of the multilevel feedback scheduler
// Requests come in on req (mode, pid), one response per request leaves on rsp
// (dispatched_pid, status). mode: ready/new, dispatch, waiting, terminate.
// Each request is taken in the idle state, where its priority entry or the
// head of the chosen level is read from memory; the exec state then writes
// back and loads the response register, raising rsp.valid, once it is free.
// One request is in flight at a time: the block takes no new request until the
// read-then-write pass over the priority table and the level queue memory has
// committed the last one.
// A held response stalls the commit; req.ready stays low until it is taken.
// After rst the priority table is swept to "unset", one entry a cycle, with
// req.ready low until the whole table is cleared; queues start empty.
// The APB port holds the default priority at byte address 0 (reset 8); writes
// are taken at any time but are meant for when the block is idle.
// A full level drops the append and reports status 3; the priority still moves.
`default_nettype none

module multilevel_feedback_scheduler_top #(
  parameter int PID_COUNT   = 4096,
  parameter int LEVELS      = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mlfs_req_if.sink                             req,
  mlfs_rsp_if.source                           rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlfs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mlfs_pkg::PDATA_W-1:0]    pwdata,
  output logic [mlfs_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  logic [mlfs_pkg::CFG_W-1:0] default_prio;
  logic                       cfg_hit;
  mlfs_pkg::ctrl_cmd_t        cmd;
  mlfs_pkg::dp_status_t       stat;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[2] == mlfs_pkg::REG_DFLT_PRIO;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_prio <= mlfs_pkg::DEFAULT_PRIO_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      default_prio <= pwdata[mlfs_pkg::CFG_W-1:0];
    end
  end

  assign prdata = cfg_hit ? mlfs_pkg::PDATA_W'(default_prio) : '0;

  mlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlfs_datapath #(
    .PID_COUNT   (PID_COUNT),
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (req.mode),
    .in_pid       (req.pid),
    .default_prio (default_prio),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_pid      (rsp.dispatched_pid),
    .out_status   (rsp.status)
  );

endmodule

`default_nettype wire

FILE: sim/mlfs_checker.sv
`timescale 1ns / 1ps
// scoreboard for the scheduler: predicts each response from observed requests and register writes, checks reads
module mlfs_checker (
  input  logic                         clk,
  input  logic                         rst,
  mlfs_req_if                          req,
  mlfs_rsp_if                          rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlfs_pkg::PADDR_W-1:0] paddr,
  input  logic [mlfs_pkg::PDATA_W-1:0] pwdata,
  input  logic [mlfs_pkg::PDATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           outstanding
);

  localparam int PID_COUNT   = 4096;
  localparam int LEVELS      = 16;
  localparam int QUEUE_DEPTH = 64;
  localparam logic [mlfs_pkg::PADDR_W-1:0] DFLT_PRIO_ADDR =
    mlfs_pkg::PADDR_W'(4 * mlfs_pkg::REG_DFLT_PRIO);

  typedef struct packed {
    logic [mlfs_pkg::PID_W-1:0] pid;
    mlfs_pkg::status_t          status;
  } sched_result_t;

  logic signed [5:0]           prio_of [PID_COUNT];
  logic [mlfs_pkg::PID_W-1:0]  level_slots [LEVELS][QUEUE_DEPTH];
  int unsigned                 level_head [LEVELS];
  int unsigned                 level_fill [LEVELS];
  logic [mlfs_pkg::CFG_W-1:0]  default_prio;
  sched_result_t               sched_results [$];

  function automatic sched_result_t apply_request(mlfs_pkg::mode_t m,
                                                  logic [mlfs_pkg::PID_W-1:0] p);
    sched_result_t r;
    int pr;
    int lv;
    int d;
    r.pid = '0;
    r.status = mlfs_pkg::STAT_DONE;
    if (m == mlfs_pkg::MODE_DISPATCH) begin
      r.status = mlfs_pkg::STAT_EMPTY;
      for (lv = 0; lv < LEVELS && r.status == mlfs_pkg::STAT_EMPTY; lv++) begin
        if (level_fill[lv] != 0) begin
          r.pid = level_slots[lv][level_head[lv]];
          level_head[lv] = (level_head[lv] + 1) % QUEUE_DEPTH;
          level_fill[lv]--;
          r.status = mlfs_pkg::STAT_DISPATCHED;
        end
      end
    end else if (int'(p) < PID_COUNT) begin
      pr = prio_of[p];
      case (m)
        mlfs_pkg::MODE_READY: begin
          d = default_prio;
          if (d < 1) d = 1;
          if (d > LEVELS) d = LEVELS;
          if (pr < 0) pr = d;
          else if (pr < LEVELS) pr++;
          if (level_fill[pr-1] >= QUEUE_DEPTH) begin
            r.status = mlfs_pkg::STAT_FULL;
          end else begin
            level_slots[pr-1][(level_head[pr-1] + level_fill[pr-1]) % QUEUE_DEPTH] = p;
            level_fill[pr-1]++;
          end
        end
        mlfs_pkg::MODE_WAITING: begin
          pr = (pr > 1) ? pr - 2 : pr - 1;
          if (pr < -1) pr = -1;
        end
        mlfs_pkg::MODE_TERMINATE: pr = 0;
        default: ;
      endcase
      prio_of[p] = 6'(pr);
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      foreach (prio_of[i]) prio_of[i] = '1;
      foreach (level_head[i]) begin
        level_head[i] = 0;
        level_fill[i] = 0;
      end
      default_prio = mlfs_pkg::DEFAULT_PRIO_RESET;
      sched_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (sched_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, got pid %0d status %0d", $time,
                   rsp.dispatched_pid, rsp.status);
        end else begin
          want = sched_results.pop_front();
          if (rsp.dispatched_pid !== want.pid || rsp.status !== want.status) begin
            errors++;
            $display("%0t: expected pid %0d status %0d, got pid %0d status %0d", $time,
                     want.pid, want.status, rsp.dispatched_pid, rsp.status);
          end
        end
      end
      if (req.valid && req.ready)
        sched_results.push_back(apply_request(mlfs_pkg::mode_t'(req.mode), req.pid));
      if (psel && penable && pready && pwrite && paddr == DFLT_PRIO_ADDR)
        default_prio = pwdata[mlfs_pkg::CFG_W-1:0];
      if (psel && penable && pready && !pwrite && paddr == DFLT_PRIO_ADDR &&
          prdata !== mlfs_pkg::PDATA_W'(default_prio)) begin
        errors++;
        $display("%0t: expected priority default %0d, got %0d", $time,
                 default_prio, prdata);
      end
    end
    outstanding = sched_results.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// top of the scheduler testbench: clock, reset, request and register stimulus, verdict
module testbench;

  localparam logic [mlfs_pkg::PADDR_W-1:0] DFLT_PRIO_ADDR =
    mlfs_pkg::PADDR_W'(4 * mlfs_pkg::REG_DFLT_PRIO);
  localparam int PHASE_ITEMS = 165;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_style_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mlfs_pkg::PADDR_W-1:0] paddr;
  logic [mlfs_pkg::PDATA_W-1:0] pwdata;
  logic [mlfs_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  int                           errors;
  int                           outstanding;
  int                           phase_items;
  int                           burst_left;
  logic [mlfs_pkg::PID_W-1:0]   pid_pool [8];

  mlfs_req_if req_ch ();
  mlfs_rsp_if rsp_ch ();

  multilevel_feedback_scheduler_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mlfs_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rx_style_t style;
    rsp_ch.ready = 1'b0;
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (style)
          RX_OPEN:   rsp_ch.ready = 1'b1;
          RX_RANDOM: rsp_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ch.ready = ($urandom_range(0, 7) == 0);
          default:   rsp_ch.ready = ~rsp_ch.ready;
        endcase
      end
    end
  end

  task automatic send_item(input mlfs_pkg::mode_t m, input logic [mlfs_pkg::PID_W-1:0] p);
    req_ch.valid = 1'b1;
    req_ch.mode  = m;
    req_ch.pid   = p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    phase_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [mlfs_pkg::PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = DFLT_PRIO_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_default(input logic [mlfs_pkg::CFG_W-1:0] v);
    settle();
    apb_access(1'b1, mlfs_pkg::PDATA_W'(v));
    apb_access(1'b0, '0);
    phase_items = 0;
    foreach (pid_pool[i]) pid_pool[i] = mlfs_pkg::PID_W'($urandom_range(0, 4095));
  endtask

  function automatic mlfs_pkg::mode_t weighted_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return mlfs_pkg::MODE_READY;
    if (r < 75) return mlfs_pkg::MODE_DISPATCH;
    if (r < 88) return mlfs_pkg::MODE_WAITING;
    return mlfs_pkg::MODE_TERMINATE;
  endfunction

  task automatic run_scenario();
    int pick;
    logic [mlfs_pkg::PID_W-1:0] p;
    pick = $urandom_range(0, 19);
    p = mlfs_pkg::PID_W'($urandom_range(0, 4095));
    if (pick == 0) begin
      // one id climbs to the top level and overflows its queue
      repeat (84) send_item(mlfs_pkg::MODE_READY, p);
      repeat (10) send_item(mlfs_pkg::MODE_DISPATCH, mlfs_pkg::PID_W'($urandom));
    end else if (pick < 3) begin
      repeat ($urandom_range(10, 40))
        send_item(mlfs_pkg::MODE_DISPATCH, mlfs_pkg::PID_W'($urandom));
    end else if (pick < 5) begin
      repeat (12)
        send_item(mlfs_pkg::mode_t'($urandom_range(0, 3)), mlfs_pkg::PID_W'($urandom));
    end else if (pick < 9) begin
      send_item(mlfs_pkg::MODE_READY, p);
      send_item(mlfs_pkg::MODE_DISPATCH, mlfs_pkg::PID_W'($urandom));
      send_item(mlfs_pkg::MODE_WAITING, p);
      send_item(mlfs_pkg::MODE_READY, p);
      send_item(mlfs_pkg::MODE_READY, p);
      send_item(mlfs_pkg::MODE_DISPATCH, mlfs_pkg::PID_W'($urandom));
      send_item(mlfs_pkg::MODE_TERMINATE, p);
      send_item(mlfs_pkg::MODE_READY, p);
      send_item(mlfs_pkg::MODE_DISPATCH, mlfs_pkg::PID_W'($urandom));
    end else begin
      repeat (20) send_item(weighted_mode(), pid_pool[$urandom_range(0, 7)]);
    end
  endtask

  initial begin
    logic [mlfs_pkg::CFG_W-1:0] cfg_plan [6];
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.mode   = mlfs_pkg::MODE_READY;
    req_ch.pid    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    phase_items   = 0;
    burst_left    = 8;
    cfg_plan      = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd8};
    cfg_plan[5]   = mlfs_pkg::CFG_W'($urandom_range(0, 31));
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // default of zero counts as one
    set_default(5'd0);
    send_item(mlfs_pkg::MODE_DISPATCH, 12'hfff);
    send_item(mlfs_pkg::MODE_READY, 12'h000);
    send_item(mlfs_pkg::MODE_READY, 12'hfff);
    send_item(mlfs_pkg::MODE_READY, 12'h000);
    send_item(mlfs_pkg::MODE_WAITING, 12'h000);
    send_item(mlfs_pkg::MODE_WAITING, 12'h000);
    send_item(mlfs_pkg::MODE_WAITING, 12'h000);
    send_item(mlfs_pkg::MODE_WAITING, 12'hfff);
    send_item(mlfs_pkg::MODE_TERMINATE, 12'haaa);
    send_item(mlfs_pkg::MODE_READY, 12'haaa);
    send_item(mlfs_pkg::MODE_READY, 12'h555);
    send_item(mlfs_pkg::MODE_TERMINATE, 12'hfff);
    send_item(mlfs_pkg::MODE_READY, 12'hfff);
    repeat (6) send_item(mlfs_pkg::MODE_DISPATCH, 12'h000);
    send_item(mlfs_pkg::MODE_DISPATCH, 12'h555);

    // default above the top level counts as the top level
    set_default(5'd31);
    send_item(mlfs_pkg::MODE_READY, 12'h007);
    send_item(mlfs_pkg::MODE_READY, 12'h007);
    send_item(mlfs_pkg::MODE_DISPATCH, 12'h000);
    send_item(mlfs_pkg::MODE_DISPATCH, 12'h000);
    send_item(mlfs_pkg::MODE_DISPATCH, 12'h000);

    foreach (cfg_plan[i]) begin
      set_default(cfg_plan[i]);
      while (phase_items < PHASE_ITEMS) run_scenario();
    end

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
